// ===== design/r2p_pkg.sv =====
`default_nettype none

package r2p_pkg;

  localparam int COORD_WIDTH_DEF    = 16;
  localparam int ROTATION_STEPS_DEF = 16;

  localparam int MAG_W     = 16;
  localparam int ANG_OUT_W = 15;

  // datapath of the rotation stages, coordinates scaled to bit 59
  localparam int XY_W        = 63;
  localparam int SCALE_TOP   = 60;
  localparam int ANG_W       = 40;
  localparam int ANG_FRAC    = 24;
  localparam int FULL_TURN   = 23040;
  localparam int HALF_TURN   = 11520;
  localparam int QUARTER_DEG = 2880;

  localparam longint unsigned DEG_NUM = 64'd381335040;
  localparam longint unsigned PI_DEN  = 64'd103993;

  localparam logic signed [ANG_W-1:0] HALF_TURN_FIX =
    ANG_W'(longint'(HALF_TURN) << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] FULL_TURN_FIX =
    ANG_W'(longint'(FULL_TURN) << ANG_FRAC);
  localparam logic [ANG_W-1:0] ROUND_HALF = ANG_W'(longint'(1) << (ANG_FRAC - 1));

  // stages after the input register, excluding padding
  localparam int MAG_EXTRA    = 3;
  localparam int CORDIC_EXTRA = 3;

  // atan(2^-idx) in 2^-24 units of 1/64 degree
  function automatic longint unsigned rot_angle(input int unsigned idx);
    longint unsigned rad;
    longint unsigned num;
    longint unsigned quo;
    longint unsigned rem_v;
    longint unsigned dvs;
    longint unsigned prod;
    int unsigned     k;
    int unsigned     p;
    int              b;
    if (idx == 0) begin
      return longint'(QUARTER_DEG) << ANG_FRAC;
    end
    rad = 64'd0;
    for (k = 0; k < 64; k++) begin
      p = idx * (2 * k + 1);
      if (p <= 36) begin
        num   = 64'd1 << (36 - p);
        dvs   = longint'(2 * k + 1);
        quo   = 64'd0;
        rem_v = 64'd0;
        for (b = 36; b >= 0; b--) begin
          rem_v = (rem_v << 1) | ((num >> b) & 64'd1);
          if (rem_v >= dvs) begin
            rem_v = rem_v - dvs;
            quo   = quo | (64'd1 << b);
          end
        end
        if (k[0]) begin
          rad = rad - quo;
        end else begin
          rad = rad + quo;
        end
      end
    end
    prod = (rad * DEG_NUM) / PI_DEN;
    return (prod + 64'd2048) >> 12;
  endfunction

endpackage

`default_nettype wire

// ===== design/r2p_mag.sv =====
`default_nettype none

module r2p_mag
  import r2p_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int LAT         = COORD_WIDTH + MAG_EXTRA
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [COORD_WIDTH-1:0] x_i,
  input  wire logic signed [COORD_WIDTH-1:0] y_i,
  output logic             [MAG_W-1:0]       magnitude_o
);

  localparam int W   = COORD_WIDTH;
  localparam int SW  = 2 * W;
  localparam int RW  = W + 2;
  localparam int PAD = LAT - (W + MAG_EXTRA);

  logic [W-1:0]  ax, ay;
  logic [SW-1:0] ax2_q, ay2_q;
  logic [SW-1:0] s_q    [W];
  logic [RW-1:0] rem_q  [W];
  logic [W-1:0]  root_q [W];
  logic          rnd;
  logic [W:0]    mag_d;
  logic [MAG_W-1:0] mag_q;

  assign ax = x_i[W-1] ? W'(-x_i) : W'(x_i);
  assign ay = y_i[W-1] ? W'(-y_i) : W'(y_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax2_q  <= SW'(ax) * SW'(ax);
      ay2_q  <= SW'(ay) * SW'(ay);
      s_q[0] <= ax2_q + ay2_q;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < W; k++) begin : g_root
    localparam int J = W - 1 - k;
    logic [RW-1:0] rem_in;
    logic [W-1:0]  root_in;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], s_q[k][2*J+1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[k]  <= rem_sh - trial;
          root_q[k] <= {root_in[W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_sh;
          root_q[k] <= {root_in[W-2:0], 1'b0};
        end
      end
    end

    if (k < W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          s_q[k+1] <= s_q[k];
        end
      end
    end
  end

  // round to nearest
  assign rnd   = rem_q[W-1] > RW'(root_q[W-1]);
  assign mag_d = (W + 1)'(root_q[W-1]) + (W + 1)'(rnd);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= MAG_W'(mag_d);
    end
  end

  if (PAD > 0) begin : g_pad
    logic [MAG_W-1:0] pad_q [PAD];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pad_q[0] <= mag_q;
        for (int p = 1; p < PAD; p++) begin
          pad_q[p] <= pad_q[p-1];
        end
      end
    end
    assign magnitude_o = pad_q[PAD-1];
  end else begin : g_nopad
    assign magnitude_o = mag_q;
  end

endmodule

`default_nettype wire

// ===== design/r2p_cordic.sv =====
`default_nettype none

module r2p_cordic
  import r2p_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int ROTATION_STEPS = ROTATION_STEPS_DEF,
  parameter int LAT            = ROTATION_STEPS + CORDIC_EXTRA
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [COORD_WIDTH-1:0] x_i,
  input  wire logic signed [COORD_WIDTH-1:0] y_i,
  output logic             [ANG_OUT_W-1:0]   angle_o
);

  localparam int N           = ROTATION_STEPS;
  localparam int SCALE_SHIFT = SCALE_TOP - COORD_WIDTH;
  localparam int AW          = ANG_W - ANG_FRAC;
  localparam int PAD         = LAT - (N + CORDIC_EXTRA);
  localparam logic [AW-1:0] TURN = AW'(FULL_TURN);

  logic signed [XY_W-1:0]  xs, ys;
  logic                    neg;
  logic signed [XY_W-1:0]  cx_q  [N];
  logic signed [XY_W-1:0]  cy_q  [N];
  logic signed [ANG_W-1:0] cz_q  [N+1];
  logic                    org_q [N+2];
  logic signed [ANG_W-1:0] fix_d, fix_q;
  logic [ANG_W-1:0]        rnd;
  logic [AW-1:0]           ang_w;
  logic [ANG_OUT_W-1:0]    ang_d, ang_q;

  assign neg = x_i[COORD_WIDTH-1];
  assign xs  = XY_W'(x_i) <<< SCALE_SHIFT;
  assign ys  = XY_W'(y_i) <<< SCALE_SHIFT;

  // fold the left half-plane over, base angle preloaded into z
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0]  <= neg ? -xs : xs;
      cy_q[0]  <= neg ? -ys : ys;
      cz_q[0]  <= neg ? HALF_TURN_FIX : '0;
      org_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [ANG_W-1:0] STEP_ANG = ANG_W'(rot_angle(i));
    logic up;

    assign up = !cy_q[i][XY_W-1] && (cy_q[i] != '0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cz_q[i+1]  <= up ? cz_q[i] + STEP_ANG : cz_q[i] - STEP_ANG;
        org_q[i+1] <= org_q[i];
      end
    end

    if (i < N - 1) begin : g_xy
      logic signed [XY_W-1:0] dx, dy;

      assign dx = cy_q[i] >>> i;
      assign dy = cx_q[i] >>> i;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          cx_q[i+1] <= up ? cx_q[i] + dx : cx_q[i] - dx;
          cy_q[i+1] <= up ? cy_q[i] - dy : cy_q[i] + dy;
        end
      end
    end
  end

  // wrap into one turn
  always_comb begin
    fix_d = cz_q[N];
    if (fix_d < 0) begin
      fix_d = fix_d + FULL_TURN_FIX;
    end
    if (fix_d < 0) begin
      fix_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fix_q    <= fix_d;
      org_q[N+1] <= org_q[N];
    end
  end

  assign rnd   = ANG_W'(fix_q) + ROUND_HALF;
  assign ang_w = rnd[ANG_W-1:ANG_FRAC];

  always_comb begin
    if (org_q[N+1]) begin
      ang_d = '0;
    end else if (ang_w >= TURN) begin
      ang_d = ANG_OUT_W'(ang_w - TURN);
    end else begin
      ang_d = ANG_OUT_W'(ang_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
    end
  end

  if (PAD > 0) begin : g_pad
    logic [ANG_OUT_W-1:0] pad_q [PAD];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pad_q[0] <= ang_q;
        for (int p = 1; p < PAD; p++) begin
          pad_q[p] <= pad_q[p-1];
        end
      end
    end
    assign angle_o = pad_q[PAD-1];
  end else begin : g_nopad
    assign angle_o = ang_q;
  end

endmodule

`default_nettype wire

// ===== design/rect_to_polar_degrees_unit.sv =====
// a request passes the input register, the longer of the root and rotation pipelines and the
// output register before its result is valid; the shorter pipeline is padded to match
// throughput: one request per cycle unless a stalled result fills the one-entry skid register
// reset: rst_ni asynchronous active low, clears all valid bits; no other state is reset
`default_nettype none

module rect_to_polar_degrees_unit
  import r2p_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int ROTATION_STEPS = ROTATION_STEPS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  wire logic signed [COORD_WIDTH-1:0] y_coord_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic             [MAG_W-1:0]       magnitude_o,
  output logic             [ANG_OUT_W-1:0]   angle_o
);

  localparam int MAG_LAT = COORD_WIDTH + MAG_EXTRA;
  localparam int CRD_LAT = ROTATION_STEPS + CORDIC_EXTRA;
  localparam int LAT     = (MAG_LAT > CRD_LAT) ? MAG_LAT : CRD_LAT;

  logic                          en;
  logic                          vld_q [LAT+1];
  logic signed [COORD_WIDTH-1:0] x_q, y_q;
  logic [MAG_W-1:0]              pipe_mag;
  logic [ANG_OUT_W-1:0]          pipe_ang;
  logic                          pipe_vld;
  logic                          out_vld_q, skid_vld_q;
  logic [MAG_W-1:0]              out_mag_q, skid_mag_q;
  logic [ANG_OUT_W-1:0]          out_ang_q, skid_ang_q;
  logic                          out_load;

  assign en         = !skid_vld_q;
  assign in_ready_o = en;
  assign pipe_vld   = vld_q[LAT] && en;
  assign out_load   = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= LAT; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s <= LAT; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= x_coord_i;
      y_q <= y_coord_i;
    end
  end

  r2p_mag #(
    .COORD_WIDTH(COORD_WIDTH),
    .LAT        (LAT)
  ) u_mag (
    .clk_i      (clk_i),
    .en_i       (en),
    .x_i        (x_q),
    .y_i        (y_q),
    .magnitude_o(pipe_mag)
  );

  r2p_cordic #(
    .COORD_WIDTH   (COORD_WIDTH),
    .ROTATION_STEPS(ROTATION_STEPS),
    .LAT           (LAT)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (x_q),
    .y_i    (y_q),
    .angle_o(pipe_ang)
  );

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q  <= skid_vld_q || pipe_vld;
      skid_vld_q <= 1'b0;
    end else if (pipe_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (skid_vld_q) begin
        out_mag_q <= skid_mag_q;
        out_ang_q <= skid_ang_q;
      end else begin
        out_mag_q <= pipe_mag;
        out_ang_q <= pipe_ang;
      end
    end else if (pipe_vld) begin
      skid_mag_q <= pipe_mag;
      skid_ang_q <= pipe_ang;
    end
  end

  assign out_valid_o = out_vld_q;
  assign magnitude_o = out_mag_q;
  assign angle_o     = out_ang_q;

endmodule

`default_nettype wire

// ===== sim/tb_rect_to_polar_degrees_unit.sv =====
module tb_rect_to_polar_degrees_unit;
  import r2p_pkg::*;

  localparam int     CW       = COORD_WIDTH_DEF;
  localparam int     ROT      = ROTATION_STEPS_DEF;
  localparam int     SCALE    = 60 - CW;
  localparam int     FRAC     = 24;
  localparam longint TURN     = 23040;
  localparam int     LATENCY  = ((CW > ROT) ? CW : ROT) + 4;
  localparam int     N_RAND   = 1880;
  localparam int     N_DIR    = 24;

  localparam longint unsigned DEG_SCALE = 64'd381335040;
  localparam longint unsigned PI_DIV    = 64'd103993;

  typedef struct packed {
    logic [MAG_W-1:0]     mag;
    logic [ANG_OUT_W-1:0] ang;
  } polar_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    polar_t               res;
  } pending_t;

  typedef struct {
    int x;
    int y;
    bit mag_set;
    int mag;
    bit ang_set;
    int ang;
  } vec_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic signed [CW-1:0] x_coord_i   = '0;
  logic signed [CW-1:0] y_coord_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [MAG_W-1:0]     magnitude_o;
  logic [ANG_OUT_W-1:0] angle_o;

  longint   atan_fix [0:ROT-1];
  pending_t polar_due [$];
  pending_t due_head;
  bit       calm_q   = 1'b0;
  int       rx_hold  = 0;
  int       n_errors = 0;
  int       corner_v [0:6] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  rect_to_polar_degrees_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .magnitude_o (magnitude_o),
    .angle_o     (angle_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm_q) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic polar_t to_polar(input logic signed [CW-1:0] xc,
                                      input logic signed [CW-1:0] yc);
    polar_t          res;
    longint          x, y, dx, dy, z;
    longint unsigned sq, r, steps;
    x = xc;
    y = yc;
    sq = x * x + y * y;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= sq) r = r | (64'd1 << b);
    end
    if (sq - r * r > r) r = r + 1;
    res.mag = MAG_W'(r);
    if (xc == 0 && yc == 0) begin
      res.ang = '0;
      return res;
    end
    z = 0;
    // left half-plane: reflect through the origin, start from half a turn
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(180 * 64) << FRAC;
    end
    x = x <<< SCALE;
    y = y <<< SCALE;
    for (int i = 0; i < ROT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_fix[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_fix[i];
      end
    end
    if (z < 0) z = z + (TURN << FRAC);
    if (z < 0) z = 0;
    steps = ($unsigned(z) + (64'd1 << (FRAC - 1))) >> FRAC;
    while (steps >= TURN) steps = steps - TURN;
    res.ang = ANG_OUT_W'(steps);
    return res;
  endfunction

  task automatic send_pair(input logic signed [CW-1:0] xv, input logic signed [CW-1:0] yv,
                           input polar_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i  <= xv;
    y_coord_i  <= yv;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    polar_due.push_back(pending_t'{xv, yv, want});
  endtask

  // result side: compare, then pick the next ready pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (polar_due.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result expected none actual mag %0d angle %0d",
                 $time, magnitude_o, angle_o);
      end else begin
        due_head = polar_due.pop_front();
        if (magnitude_o !== due_head.res.mag) begin
          n_errors++;
          $display("%0t: magnitude x=%0d y=%0d expected %0d actual %0d", $time,
                   due_head.x, due_head.y, due_head.res.mag, magnitude_o);
        end
        if (angle_o !== due_head.res.ang) begin
          n_errors++;
          $display("%0t: angle x=%0d y=%0d expected %0d actual %0d", $time,
                   due_head.x, due_head.y, due_head.res.ang, angle_o);
        end
      end
    end
    if (rx_hold == 0) begin
      if (calm_q) begin
        out_ready_i <= 1'b1;
        rx_hold = 1;
      end else if ($urandom_range(0, 99) < 65) begin
        out_ready_i <= 1'b1;
        rx_hold = $urandom_range(1, 8);
      end else begin
        out_ready_i <= 1'b0;
        rx_hold = pick_gap() + 1;
      end
    end
    rx_hold--;
  end

  initial begin : stim
    vec_row_t             dir_tab [0:N_DIR-1];
    polar_t               want;
    logic signed [CW-1:0] xv, yv;
    longint unsigned      rad, term, prod;
    int                   kind, m;

    // arctangent table in 2^-24 steps of 1/64 degree
    for (int i = 0; i < ROT; i++) begin
      if (i == 0) begin
        atan_fix[i] = longint'(45 * 64) << FRAC;
      end else begin
        rad = 0;
        for (int k = 0; i * (2 * k + 1) <= 36; k++) begin
          term = (64'd1 << (36 - i * (2 * k + 1))) / longint'(2 * k + 1);
          if (k % 2 == 1) rad = rad - term;
          else rad = rad + term;
        end
        prod = rad * DEG_SCALE / PI_DIV;
        atan_fix[i] = longint'((prod + 64'd2048) >> 12);
      end
    end

    dir_tab = '{
      '{0, 0, 1, 0, 1, 0},
      '{32767, 0, 1, 32767, 0, 0},
      '{-32768, 0, 1, 32768, 0, 0},
      '{0, 32767, 1, 32767, 0, 0},
      '{0, -32768, 1, 32768, 0, 0},
      '{32767, 32767, 1, 46340, 0, 0},
      '{-32768, -32768, 1, 46341, 0, 0},
      '{-32768, 32767, 1, 46340, 0, 0},
      '{32767, -32768, 1, 46340, 0, 0},
      '{3, 4, 1, 5, 0, 0},
      '{-3, 4, 1, 5, 0, 0},
      '{-3, -4, 1, 5, 0, 0},
      '{3, -4, 1, 5, 0, 0},
      '{1, 0, 1, 1, 0, 0},
      '{0, 1, 1, 1, 0, 0},
      '{-1, 0, 1, 1, 0, 0},
      '{0, -1, 1, 1, 0, 0},
      '{1, 1, 1, 1, 0, 0},
      '{-1, -1, 1, 1, 0, 0},
      '{5, -12, 1, 13, 0, 0},
      '{-1, 32767, 1, 32767, 0, 0},
      '{32767, 1, 1, 32767, 0, 0},
      '{-32768, -1, 1, 32768, 0, 0},
      '{0, 0, 1, 0, 1, 0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int j = 0; j < N_DIR; j++) begin
      xv   = CW'(dir_tab[j].x);
      yv   = CW'(dir_tab[j].y);
      want = to_polar(xv, yv);
      if (dir_tab[j].mag_set) want.mag = MAG_W'(dir_tab[j].mag);
      if (dir_tab[j].ang_set) want.ang = ANG_OUT_W'(dir_tab[j].ang);
      send_pair(xv, yv, want);
    end

    for (int n = 0; n < N_RAND; n++) begin
      calm_q <= ((n / 150) % 5) == 4;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        xv = CW'($urandom);
        yv = CW'($urandom);
      end else if (kind < 60) begin
        xv = CW'(int'($urandom_range(0, 127)) - 64);
        yv = CW'(int'($urandom_range(0, 127)) - 64);
      end else if (kind < 70) begin
        // on an axis, origin now and then
        if ($urandom_range(0, 1)) begin
          xv = '0;
          yv = CW'($urandom);
        end else begin
          xv = CW'($urandom);
          yv = '0;
        end
      end else if (kind < 80) begin
        xv = CW'(corner_v[$urandom_range(0, 6)]);
        yv = CW'(corner_v[$urandom_range(0, 6)]);
      end else if (kind < 90) begin
        // diagonals
        m  = $urandom_range(0, 32768);
        xv = CW'($urandom_range(0, 1) ? -m : m);
        yv = CW'($urandom_range(0, 1) ? -m : m);
      end else begin
        // close to an axis
        xv = CW'($urandom);
        yv = CW'(int'($urandom_range(0, 6)) - 3);
        if ($urandom_range(0, 1)) begin
          m  = xv;
          xv = yv;
          yv = CW'(m);
        end
      end
      send_pair(xv, yv, to_polar(xv, yv));
    end
    in_valid_i <= 1'b0;

    while (polar_due.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #15000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
design/r2p_pkg.sv
design/r2p_mag.sv
design/r2p_cordic.sv
design/rect_to_polar_degrees_unit.sv
sim/tb_rect_to_polar_degrees_unit.sv
